[sv/rls_pkg.sv]
// rls_pkg: shared types and codes for the register liveness solver
// holds item modes, fixed field widths and the controller/datapath command and status structs
// no dependencies
package rls_pkg;

    // fixed field widths of the item ports
    localparam int BLK_W  = 5;
    localparam int MASK_W = 32;
    localparam int CNT_W  = 6;
    localparam int MODE_W = 2;

    // item modes
    localparam logic [MODE_W-1:0] MODE_INSTR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SOLVE = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load_instr;
        logic load_edge;
        logic acc_clear;
        logic acc_step;
        logic update;
        logic emit_load;
        logic emit_last;
        logic clear_all;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic changed;
    } dp_status_t;

endpackage

[sv/rls_datapath.sv]
// rls_datapath: gen/kill/successor stores, live-in/live-out stores, out accumulator
// and the output payload registers; driven by rls_controller commands
// depends on rls_pkg
module rls_datapath
    import rls_pkg::*;
#(
    parameter int MAX_BLOCKS = 32,
    parameter int REG_BITS   = 32,
    parameter int IW         = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  logic [IW-1:0]     row_idx,
    input  logic [IW-1:0]     col_idx,
    input  logic [BLK_W-1:0]  block,
    input  logic [BLK_W-1:0]  successor,
    input  logic [MASK_W-1:0] use_mask,
    input  logic [MASK_W-1:0] def_mask,
    output dp_status_t        status,
    output logic [BLK_W-1:0]  result_block,
    output logic [MASK_W-1:0] live_in,
    output logic [MASK_W-1:0] live_out,
    output logic              last
);

    // stored entries: the block field reaches 32 blocks at most
    localparam int NB = (MAX_BLOCKS < 32) ? MAX_BLOCKS : 32;
    localparam int AW = $clog2(NB);
    // effective register mask width
    localparam int RW = (REG_BITS < MASK_W) ? REG_BITS : MASK_W;
    localparam logic [BLK_W:0] NB_BLK = (BLK_W + 1)'(NB);
    localparam logic [IW:0]    NB_IDX = (IW + 1)'(NB);

    logic [RW-1:0] gen_reg  [NB];
    logic [RW-1:0] kill_reg [NB];
    logic [NB-1:0] succ_reg [NB];
    logic [RW-1:0] lin_reg  [NB];
    logic [RW-1:0] lout_reg [NB];
    logic [RW-1:0] acc_reg;
    logic [RW-1:0] acc_next;

    logic [BLK_W-1:0]  res_blk_reg;
    logic [MASK_W-1:0] res_in_reg;
    logic [MASK_W-1:0] res_out_reg;
    logic              res_last_reg;

    logic          ld_ok;
    logic          ed_ok;
    logic          row_ok;
    logic          col_ok;
    logic [AW-1:0] ld_addr;
    logic [AW-1:0] sc_addr;
    logic [AW-1:0] row_addr;
    logic [AW-1:0] col_addr;
    logic [RW-1:0] gen_row;
    logic [RW-1:0] kill_row;
    logic [NB-1:0] succ_row;
    logic [RW-1:0] lout_row;
    logic [RW-1:0] lin_col;
    logic [RW-1:0] new_in;
    logic [RW-1:0] use_m;
    logic [RW-1:0] def_m;
    logic [NB-1:0] edge_bit;
    logic          succ_hit;
    logic          changed;

    // address decode and range checks
    assign ld_ok    = {1'b0, block} < NB_BLK;
    assign ed_ok    = ld_ok && ({1'b0, successor} < NB_BLK);
    assign row_ok   = {1'b0, row_idx} < NB_IDX;
    assign col_ok   = {1'b0, col_idx} < NB_IDX;
    assign ld_addr  = block[AW-1:0];
    assign sc_addr  = successor[AW-1:0];
    assign row_addr = (cmd.load_instr || cmd.load_edge) ? ld_addr : row_idx[AW-1:0];
    assign col_addr = col_idx[AW-1:0];
    assign use_m    = use_mask[RW-1:0];
    assign def_m    = def_mask[RW-1:0];
    assign edge_bit = {{(NB-1){1'b0}}, 1'b1} << sc_addr;

    // one read port per store
    assign gen_row  = gen_reg[row_addr];
    assign kill_row = kill_reg[row_addr];
    assign succ_row = succ_reg[row_addr];
    assign lout_row = lout_reg[row_addr];
    assign lin_col  = lin_reg[col_addr];

    // successor fold and transfer function
    assign succ_hit = row_ok && col_ok && succ_row[col_addr];
    assign acc_next = cmd.acc_clear ? '0 :
                      (cmd.acc_step && succ_hit) ? (acc_reg | lin_col) : acc_reg;
    assign new_in   = gen_row | (acc_reg & ~kill_row);
    assign changed  = row_ok && ((acc_reg != lout_row) || (new_in != lin_col));
    assign status.changed = changed;

    // stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NB; i++)
            begin
                gen_reg[i]  <= '0;
                kill_reg[i] <= '0;
                succ_reg[i] <= '0;
                lin_reg[i]  <= '0;
                lout_reg[i] <= '0;
            end
        end
        else if (cmd.clear_all)
        begin
            for (int i = 0; i < NB; i++)
            begin
                gen_reg[i]  <= '0;
                kill_reg[i] <= '0;
                succ_reg[i] <= '0;
                lin_reg[i]  <= '0;
                lout_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load_instr && ld_ok)
            begin
                gen_reg[row_addr]  <= gen_row | (use_m & ~kill_row);
                kill_reg[row_addr] <= kill_row | def_m;
            end
            if (cmd.load_edge && ed_ok)
            begin
                succ_reg[row_addr] <= succ_row | edge_bit;
            end
            if (cmd.update && changed)
            begin
                lin_reg[row_addr]  <= new_in;
                lout_reg[row_addr] <= acc_reg;
            end
        end
    end

    // out accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            res_blk_reg  <= BLK_W'(row_idx);
            res_in_reg   <= row_ok ? MASK_W'(lin_col) : '0;
            res_out_reg  <= row_ok ? MASK_W'(lout_row) : '0;
            res_last_reg <= cmd.emit_last;
        end
    end

    assign result_block = res_blk_reg;
    assign live_in      = res_in_reg;
    assign live_out     = res_out_reg;
    assign last         = res_last_reg;

endmodule

[sv/rls_controller.sv]
// rls_controller: state machine for loading, sweeping to a fixed point and emitting
// owns the block and successor counters, the change flag and output valid
// depends on rls_pkg
module rls_controller
    import rls_pkg::*;
#(
    parameter int MAX_BLOCKS = 32,
    parameter int IW         = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MODE_W-1:0] mode,
    input  logic [CNT_W-1:0]  block_count,
    output logic              out_valid,
    input  logic              out_ready,
    input  dp_status_t        status,
    output dp_cmd_t           cmd,
    output logic [IW-1:0]     row_idx,
    output logic [IW-1:0]     col_idx
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CNT_W:0] MAX_CNT = (CNT_W + 1)'(MAX_BLOCKS);
    localparam logic [CW-1:0]  CNT_ONE = {{(CW-1){1'b0}}, 1'b1};

    // state codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]    state_reg,   state_next;
    logic [CW-1:0] count_reg,   count_next;
    logic [IW-1:0] blk_reg,     blk_next;
    logic [IW-1:0] scan_reg,    scan_next;
    logic          changed_reg, changed_next;
    logic          valid_reg,   valid_next;

    logic [CNT_W:0] cnt_ext;
    logic [CNT_W:0] cnt_sat;
    logic [CW-1:0]  sat_cnt;
    logic [CW-1:0]  sat_m1;
    logic [CW-1:0]  cnt_m1;
    logic [IW-1:0]  sat_last;
    logic [IW-1:0]  last_idx;
    logic           any_change;
    logic           slot_free;

    // count saturation and last index
    assign cnt_ext    = {1'b0, block_count};
    assign cnt_sat    = (cnt_ext > MAX_CNT) ? MAX_CNT : cnt_ext;
    assign sat_cnt    = cnt_sat[CW-1:0];
    assign sat_m1     = sat_cnt - CNT_ONE;
    assign cnt_m1     = count_reg - CNT_ONE;
    assign sat_last   = sat_m1[IW-1:0];
    assign last_idx   = cnt_m1[IW-1:0];
    assign any_change = changed_reg || status.changed;
    assign slot_free  = !valid_reg || out_ready;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = valid_reg;
    assign row_idx   = blk_reg;
    assign col_idx   = (state_reg == ST_SCAN) ? scan_reg : blk_reg;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        blk_next     = blk_reg;
        scan_next    = scan_reg;
        changed_next = changed_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        MODE_INSTR: cmd.load_instr = 1'b1;
                        MODE_EDGE:  cmd.load_edge  = 1'b1;
                        MODE_SOLVE:
                        begin
                            count_next = sat_cnt;
                            if (sat_cnt == '0)
                            begin
                                cmd.clear_all = 1'b1;
                            end
                            else
                            begin
                                cmd.acc_clear = 1'b1;
                                blk_next      = sat_last;
                                scan_next     = '0;
                                changed_next  = 1'b0;
                                state_next    = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.acc_step = 1'b1;
                if (scan_reg == last_idx)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_UPDATE:
            begin
                cmd.update    = 1'b1;
                cmd.acc_clear = 1'b1;
                scan_next     = '0;
                if (blk_reg == '0)
                begin
                    if (any_change)
                    begin
                        blk_next     = last_idx;
                        changed_next = 1'b0;
                        state_next   = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    blk_next     = blk_reg - 1'b1;
                    changed_next = any_change;
                    state_next   = ST_SCAN;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (blk_reg == last_idx)
                    begin
                        cmd.emit_last = 1'b1;
                        cmd.clear_all = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        blk_next = blk_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output valid
    always_comb
    begin
        if (cmd.emit_load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            blk_reg     <= '0;
            scan_reg    <= '0;
            changed_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            blk_reg     <= blk_next;
            scan_reg    <= scan_next;
            changed_reg <= changed_next;
            valid_reg   <= valid_next;
        end
    end

endmodule

[sv/register_liveness_solver_unit.sv]
// register_liveness_solver_unit: backward register liveness solver, top level
// instruction, edge and unknown-mode items are taken in idle and keep it idle; a solve
// of N blocks sweeps from the last block down to block 0 until a sweep changes nothing,
// then emits one result per block, holding each while out_ready is low; the serial
// successor scan (one successor per cycle) sets the sweep length
// reset clears all stores at once; each solve clears them again with its last result, or at once if N is zero
module register_liveness_solver_unit
    import rls_pkg::*;
#(
    parameter int MAX_BLOCKS = 32,
    parameter int REG_BITS   = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MODE_W-1:0] mode,
    input  logic [BLK_W-1:0]  block,
    input  logic [BLK_W-1:0]  successor,
    input  logic [MASK_W-1:0] use_mask,
    input  logic [MASK_W-1:0] def_mask,
    input  logic [CNT_W-1:0]  block_count,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BLK_W-1:0]  result_block,
    output logic [MASK_W-1:0] live_in,
    output logic [MASK_W-1:0] live_out,
    output logic              last
);

    localparam int IW = $clog2(MAX_BLOCKS);

    dp_cmd_t       cmd;
    dp_status_t    status;
    logic [IW-1:0] row_idx;
    logic [IW-1:0] col_idx;

    // sequencer
    rls_controller #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IW         (IW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .block_count (block_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .cmd         (cmd),
        .row_idx     (row_idx),
        .col_idx     (col_idx)
    );

    // stores and transfer function
    rls_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .REG_BITS   (REG_BITS),
        .IW         (IW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .row_idx      (row_idx),
        .col_idx      (col_idx),
        .block        (block),
        .successor    (successor),
        .use_mask     (use_mask),
        .def_mask     (def_mask),
        .status       (status),
        .result_block (result_block),
        .live_in      (live_in),
        .live_out     (live_out),
        .last         (last)
    );

    // at most one of load_instr, load_edge, update and emit_load per cycle
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_instr, cmd.load_edge, cmd.update, cmd.emit_load}))
        else $error("conflicting datapath commands");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> (!out_valid || out_ready))
        else $error("result register loaded while a result waits");

    // results of one solve follow each other without a gap
    a_emit_streams: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last && !in_ready) |=> out_valid)
        else $error("result stream broke before the last block");

    // the last result hands control back to item intake
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_last) |=> in_ready)
        else $error("not idle after the last result was loaded");

endmodule
